@@ hdl/decimal_text_to_binary64_core_assert.svh @@
// Assertion macros shared by the converter modules.
// Each macro checks one property on the rising clock edge, with the reset as disable.
`ifndef DECIMAL_TEXT_TO_BINARY64_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_BINARY64_CORE_ASSERT_SVH
`ifndef SYNTH
`define DTB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");
`define DTB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");
`else
`define DTB_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define DTB_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hdl/dtb_pkg.sv @@
package dtb_pkg;

  // Largest mantissa that still takes another digit without overflowing 64 bits.
  localparam logic [63:0] MANT_LIMIT = 64'h1999_9999_9999_9998;

  // 1 - 1e-28 * 2^93 as a fraction scaled by 2^70 (64 bits), high and low words.
  localparam logic [31:0] K_HI = 32'h9E12_835F;
  localparam logic [31:0] K_LO = 32'h3FCD_7C9E;

  localparam int DEC_MAX_EXP = 310;
  localparam int DEC_MIN_EXP = -345;
  localparam int DOUBLE_BIAS = 1023;
  localparam int EXP_INF     = 2047;
  localparam int EACC_LIM    = 32767;

  localparam int JOB_DEPTH    = 4;
  localparam int JOB_PTR_BITS = 2;
  localparam int JOB_CNT_BITS = 3;

  typedef struct packed {
    logic               failed;
    logic               negative;
    logic               sticky;
    logic [63:0]        mant;
    logic signed [15:0] dexp;
    logic [15:0]        used;
  } dtb_job_t;

endpackage

@@ hdl/decimal_text_to_binary64_core.sv @@
// Channel   | Signals                                         | Transaction when
// ----------+-------------------------------------------------+---------------------------
// text in   | char_code, string_start / push, full            | push high, full low
// result    | result_bits, chars_used, conversion_failed /    | pop high, empty low
//           | empty, pop                                      |
//
// The parser takes one character per cycle; full is the four-entry job queue being full, so
// characters stall only while four finished parses wait for the converter. Per job the
// converter takes it from the queue, shifts out each leading-zero bit, runs each step of
// 1e-28 on its single 32x32 multiplier (three partial products, a fix-up), each of 1000 or
// 10 by shift and add, closes the scaling and packs, waiting while a result is unpopped.
// Reset (rst, synchronous) empties the queue and the result register and idles the parser.
module decimal_text_to_binary64_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_code,
  input  logic        string_start,
  input  logic        push,
  output logic        full,
  output logic [63:0] result_bits,
  output logic [15:0] chars_used,
  output logic        conversion_failed,
  output logic        empty,
  input  logic        pop
);
  import dtb_pkg::*;

  logic     accept;
  logic     job_push;
  dtb_job_t job_in;
  dtb_job_t job_out;
  logic     job_empty;
  logic     job_pop;

  // A character transaction completes whenever the job queue can take a possible result.
  assign accept = push && !full;

  dtb_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .char_code    (char_code),
    .string_start (string_start),
    .job_push     (job_push),
    .job          (job_in)
  );

  // Finished parses wait here so the parser waits on the converter's loop only when the queue is full.
  dtb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // The converter scales the decimal mantissa and holds the result until it is popped.
  dtb_back u_back (
    .clk               (clk),
    .rst               (rst),
    .job_valid         (!job_empty),
    .job               (job_out),
    .job_pop           (job_pop),
    .result_bits       (result_bits),
    .chars_used        (chars_used),
    .conversion_failed (conversion_failed),
    .empty             (empty),
    .pop               (pop)
  );

endmodule

@@ hdl/dtb_front.sv @@
module dtb_front #(
  parameter int POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_code,
  input  logic              string_start,
  output logic              job_push,
  output dtb_pkg::dtb_job_t job
);
  import dtb_pkg::*;

  localparam int UW = (POSITION_BITS > 16) ? POSITION_BITS : 16;

  typedef enum logic [2:0] {
    P_IDLE, P_WS, P_INT, P_FRAC, P_EXPM, P_EXPS, P_EXPD
  } phase_t;

  phase_t                   phase, phase_next;
  logic [63:0]              mant, mant_next;
  logic                     sticky, sticky_next;
  logic                     neg, neg_next;
  logic signed [15:0]       eacc, eacc_next;
  logic [15:0]              evalue, evalue_next;
  logic                     eneg, eneg_next;
  logic                     seen, seen_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] aend, aend_next;

  function automatic logic signed [15:0] clamp_exp(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sd32767;
    end else if (v < -18'sd32767) begin
      return -16'sd32767;
    end
    return v[15:0];
  endfunction

  logic [7:0]                digit8;
  logic [3:0]                digit;
  logic                      is_dig;
  logic                      is_sign;
  logic                      done;
  logic                      frac;
  logic signed [17:0]        lim;
  logic [19:0]               ev_wide;
  logic [POSITION_BITS-1:0]  used_src;
  logic [UW-1:0]             used_ext;

  assign digit8  = char_code - 8'h30;
  assign digit   = digit8[3:0];
  assign is_dig  = (digit8 <= 8'd9);
  assign is_sign = (char_code == 8'h2B) || (char_code == 8'h2D);

  always_comb begin
    phase_next  = phase;
    mant_next   = mant;
    sticky_next = sticky;
    neg_next    = neg;
    eacc_next   = eacc;
    evalue_next = evalue;
    eneg_next   = eneg;
    seen_next   = seen;
    pos_next    = pos;
    aend_next   = aend;
    job_push    = 1'b0;
    job         = '0;
    done        = 1'b0;
    frac        = 1'b0;
    lim         = '0;
    ev_wide     = '0;
    used_src    = aend;
    used_ext    = '0;

    if (accept) begin
      if (string_start) begin
        mant_next   = '0;
        sticky_next = 1'b0;
        neg_next    = 1'b0;
        eacc_next   = '0;
        evalue_next = '0;
        eneg_next   = 1'b0;
        seen_next   = 1'b0;
        pos_next    = '0;
        aend_next   = '0;
        phase_next  = P_WS;
      end
      if (phase_next == P_IDLE) begin
        done = 1'b1;
      end

      if (!done && phase_next == P_WS) begin
        if (char_code >= 8'd1 && char_code <= 8'd32) begin
          if (pos_next != '1) pos_next = pos_next + 1'b1;
          done = 1'b1;
        end else begin
          phase_next = P_INT;
          if (is_sign) begin
            neg_next = (char_code == 8'h2D);
            if (pos_next != '1) pos_next = pos_next + 1'b1;
            done = 1'b1;
          end
        end
      end

      if (!done && (phase_next == P_INT || phase_next == P_FRAC)) begin
        done = 1'b1;
        frac = (phase_next == P_FRAC);
        if (is_dig) begin
          if (mant_next <= MANT_LIMIT) begin
            mant_next = (mant_next << 3) + (mant_next << 1) + 64'(digit);
            if (frac) eacc_next = clamp_exp(18'(eacc_next) - 18'sd1);
          end else begin
            if (!frac) eacc_next = clamp_exp(18'(eacc_next) + 18'sd1);
            if (digit != 4'd0) sticky_next = 1'b1;
          end
          seen_next = 1'b1;
          if (pos_next != '1) pos_next = pos_next + 1'b1;
        end else if (!frac && char_code == 8'h2E) begin
          phase_next = P_FRAC;
          if (pos_next != '1) pos_next = pos_next + 1'b1;
        end else if (!seen_next) begin
          job_push   = 1'b1;
          job.failed = 1'b1;
          phase_next = P_IDLE;
        end else begin
          aend_next = pos_next;
          if (char_code == 8'h65 || char_code == 8'h45) begin
            phase_next = P_EXPM;
            if (pos_next != '1) pos_next = pos_next + 1'b1;
          end else begin
            job_push   = 1'b1;
            used_src   = aend_next;
            phase_next = P_IDLE;
          end
        end
      end

      if (!done && phase_next == P_EXPM && is_sign) begin
        eneg_next  = (char_code == 8'h2D);
        phase_next = P_EXPS;
        if (pos_next != '1) pos_next = pos_next + 1'b1;
        done = 1'b1;
      end

      if (!done && is_dig) begin
        phase_next = P_EXPD;
        lim = eneg_next ? (18'sd345 + 18'(eacc_next)) : (18'sd310 - 18'(eacc_next));
        if (lim < 0 || $signed({2'b00, evalue_next}) <= lim) begin
          ev_wide     = ({4'b0, evalue_next} << 3) + ({4'b0, evalue_next} << 1) + 20'(digit);
          evalue_next = (ev_wide > 20'hFFFF) ? 16'hFFFF : ev_wide[15:0];
        end
        if (pos_next != '1) pos_next = pos_next + 1'b1;
        done = 1'b1;
      end

      if (!done) begin
        job_push   = 1'b1;
        phase_next = P_IDLE;
        if (phase_next == P_EXPD || phase == P_EXPD) begin
          eacc_next = clamp_exp(eneg_next ? (18'(eacc_next) - $signed({2'b00, evalue_next}))
                                          : (18'(eacc_next) + $signed({2'b00, evalue_next})));
          used_src  = pos_next;
        end else begin
          used_src  = aend_next;
        end
      end

      if (job_push && !job.failed) begin
        used_ext     = UW'(used_src);
        job.negative = neg_next;
        job.sticky   = sticky_next;
        job.mant     = mant_next;
        job.dexp     = eacc_next;
        job.used     = (used_ext > UW'(17'h0FFFF)) ? 16'hFFFF : used_ext[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= P_IDLE;
      mant   <= '0;
      sticky <= 1'b0;
      neg    <= 1'b0;
      eacc   <= '0;
      evalue <= '0;
      eneg   <= 1'b0;
      seen   <= 1'b0;
      pos    <= '0;
      aend   <= '0;
    end else begin
      phase  <= phase_next;
      mant   <= mant_next;
      sticky <= sticky_next;
      neg    <= neg_next;
      eacc   <= eacc_next;
      evalue <= evalue_next;
      eneg   <= eneg_next;
      seen   <= seen_next;
      pos    <= pos_next;
      aend   <= aend_next;
    end
  end

endmodule

@@ hdl/dtb_queue.sv @@
module dtb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dtb_pkg::dtb_job_t din,
  output logic              full,
  input  logic              pop,
  output dtb_pkg::dtb_job_t dout,
  output logic              empty
);
  import dtb_pkg::*;

  dtb_job_t                mem [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [JOB_CNT_BITS-1:0] count;
  logic                    do_push, do_pop;

  assign full    = (count == JOB_CNT_BITS'(JOB_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/dtb_back.sv @@
module dtb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  dtb_pkg::dtb_job_t job,
  output logic              job_pop,
  output logic [63:0]       result_bits,
  output logic [15:0]       chars_used,
  output logic              conversion_failed,
  output logic              empty,
  input  logic              pop
);
  import dtb_pkg::*;
  `include "decimal_text_to_binary64_core_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_NORM, S_SCALE, S_MUL0, S_MUL1, S_MUL2, S_FIX, S_PACK
  } state_t;

  typedef enum logic [1:0] {K_NUM, K_ZERO, K_INF, K_FAIL} kind_t;

  state_t             state;
  kind_t              kind;
  logic [63:0]        hi;
  logic [31:0]        lo;
  logic signed [15:0] e;
  logic signed [13:0] be;
  logic               scaled, sticky, neg;
  logic [15:0]        used;
  logic [63:0]        d;
  logic               out_valid;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [95:0]  x, y3;
  logic [96:0]  s1;
  logic [31:0]  dl;
  logic [63:0]  hn;
  logic [31:0]  ln;
  logic [63:0]  pm;
  logic [63:0]  pm2;
  logic signed [13:0] pe;
  logic [63:0]  packed_r;
  logic [12:0]  rem;

  assign job_pop = (state == S_IDLE) && job_valid;
  assign empty   = !out_valid;

  // One shared 32x32 multiplier serves the three partial products of the 1e-28 step.
  always_comb begin
    case (state)
      S_MUL0:  begin mul_a = hi[63:32]; mul_b = K_HI; end
      S_MUL1:  begin mul_a = hi[63:32]; mul_b = K_LO; end
      default: begin mul_a = hi[31:0];  mul_b = K_HI; end
    endcase
  end
  assign prod = mul_a * mul_b;

  assign x  = {hi, lo};
  assign y3 = x - (x >> 6) - (x >> 7);
  assign s1 = {1'b0, x} + {1'b0, x >> 2};
  assign dl = {d[5:0], 26'b0};
  assign hn = hi - {6'b0, d[63:6]} - 64'(dl >= lo);
  assign ln = lo - dl;

  // Rounding to nearest even; the mantissa is doubled to drop its leading one.
  always_comb begin
    pm       = hi | 64'(sticky);
    pm2      = pm << 1;
    pe       = be + 14'sd1023;
    rem      = {1'b0, pm2[11:0]} | 13'(pm2[12]);
    packed_r = {pe[11:0], pm2[63:12]} + 64'(rem > 13'h800);
    if (pe >= 14'sd2047) begin
      packed_r = {1'b0, 11'h7FF, 52'b0};
    end else if (pe < 14'sd1) begin
      packed_r = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PACK && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            hi     <= job.mant;
            lo     <= '0;
            e      <= job.dexp;
            be     <= 14'sd63;
            scaled <= (job.dexp != 16'sd0);
            sticky <= job.sticky;
            neg    <= job.negative;
            used   <= job.used;
            if (job.failed) begin
              kind  <= K_FAIL;
              state <= S_PACK;
            end else if (job.mant == '0 || job.dexp <= 16'(DEC_MIN_EXP)) begin
              kind  <= K_ZERO;
              state <= S_PACK;
            end else if (job.dexp >= 16'(DEC_MAX_EXP)) begin
              kind  <= K_INF;
              state <= S_PACK;
            end else begin
              kind  <= K_NUM;
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (hi[63]) begin
            state <= S_SCALE;
          end else begin
            hi <= hi << 1;
            be <= be - 14'sd1;
          end
        end
        S_SCALE: begin
          if (e < 0) begin
            state <= S_MUL0;
          end else if (e > 16'sd2) begin
            e <= e - 16'sd3;
            if (y3[95]) begin
              {hi, lo} <= y3;
              be       <= be + 14'sd10;
            end else begin
              {hi, lo} <= y3 << 1;
              be       <= be + 14'sd9;
            end
          end else if (e > 16'sd0) begin
            e <= e - 16'sd1;
            if (s1[96]) begin
              {hi, lo} <= s1[96:1];
              be       <= be + 14'sd4;
            end else begin
              {hi, lo} <= s1[95:0];
              be       <= be + 14'sd3;
            end
          end else begin
            if (scaled) hi[0] <= hi[0] | lo[31];
            state <= S_PACK;
          end
        end
        S_MUL0: begin
          d     <= prod;
          state <= S_MUL1;
        end
        S_MUL1: begin
          d     <= d + {32'b0, prod[63:32]};
          state <= S_MUL2;
        end
        S_MUL2: begin
          d     <= d + {32'b0, prod[63:32]};
          state <= S_FIX;
        end
        S_FIX: begin
          e <= e + 16'sd28;
          if (hn[63]) begin
            hi <= hn;
            lo <= ln;
            be <= be - 14'sd93;
          end else begin
            hi <= {hn[62:0], ln[31]};
            lo <= ln << 1;
            be <= be - 14'sd94;
          end
          state <= S_SCALE;
        end
        S_PACK: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
            case (kind)
              K_FAIL: begin
                result_bits       <= '0;
                chars_used        <= '0;
                conversion_failed <= 1'b1;
              end
              K_ZERO: begin
                result_bits       <= {neg, 63'b0};
                chars_used        <= used;
                conversion_failed <= 1'b0;
              end
              K_INF: begin
                result_bits       <= {neg, 11'h7FF, 52'b0};
                chars_used        <= used;
                conversion_failed <= 1'b0;
              end
              default: begin
                result_bits       <= {neg, 63'b0} | packed_r;
                chars_used        <= used;
                conversion_failed <= 1'b0;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DTB_ASSERT_IMP(a_norm_nonzero, clk, rst, state == S_NORM, hi != '0)
  `DTB_ASSERT_IMP(a_pack_normalized, clk, rst, state == S_PACK && kind == K_NUM, hi[63])
  `DTB_ASSERT_NXT(a_pop_drains, clk, rst, pop && out_valid && state != S_PACK, !out_valid)

endmodule
